// File: sv/assert_macros.svh
// Assertion macros used by the parser core.
// Each macro expects a clock i_clk and a synchronous active-low reset i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define RAP_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define RAP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RAP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/rap_pkg.sv
// Package of the array command parser: phase codes, event and error codes,
// character constants, limits and the structs passed between modules. No dependencies.
package rap_pkg;

    // Compile-time limits on the configured values.
    localparam logic [15:0] COUNT_LIMIT  = 16'd4095;
    localparam logic [31:0] LENGTH_LIMIT = 32'd1048575;

    // Field widths.
    localparam int CNT_W   = 12;
    localparam int LEN_W   = 20;
    localparam int ACC_W   = 21;
    localparam int BYTES_W = 32;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

    // Parser phases.
    localparam logic [3:0] PH_IDLE       = 4'd0;
    localparam logic [3:0] PH_DISCARD    = 4'd1;
    localparam logic [3:0] PH_CNT_START  = 4'd2;
    localparam logic [3:0] PH_CNT_DIGITS = 4'd3;
    localparam logic [3:0] PH_CNT_LF     = 4'd4;
    localparam logic [3:0] PH_ARG_PREFIX = 4'd5;
    localparam logic [3:0] PH_LEN_START  = 4'd6;
    localparam logic [3:0] PH_LEN_DIGITS = 4'd7;
    localparam logic [3:0] PH_LEN_LF     = 4'd8;
    localparam logic [3:0] PH_DATA       = 4'd9;
    localparam logic [3:0] PH_DATA_CR    = 4'd10;
    localparam logic [3:0] PH_DATA_LF    = 4'd11;

    // Event kinds.
    localparam logic [2:0] EV_ARRAY_HDR = 3'd0;
    localparam logic [2:0] EV_ARG_HDR   = 3'd1;
    localparam logic [2:0] EV_DATA      = 3'd2;
    localparam logic [2:0] EV_ARG_END   = 3'd3;
    localparam logic [2:0] EV_ERROR     = 3'd4;

    // Error codes.
    localparam logic [2:0] ERR_BAD_TYPE   = 3'd0;
    localparam logic [2:0] ERR_BAD_COUNT  = 3'd1;
    localparam logic [2:0] ERR_COUNT_BIG  = 3'd2;
    localparam logic [2:0] ERR_BAD_PREFIX = 3'd3;
    localparam logic [2:0] ERR_BAD_LENGTH = 3'd4;
    localparam logic [2:0] ERR_TOO_LONG   = 3'd5;
    localparam logic [2:0] ERR_BAD_TERM   = 3'd6;

    // Configuration register indexes.
    localparam logic REG_MAX_ARGUMENTS   = 1'b0;
    localparam logic REG_MAX_BULK_LENGTH = 1'b1;

    // Characters of the framing.
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Effective limits, as seen by the parser.
    typedef struct packed {
        logic [ACC_W-1:0] cnt_lim;
        logic [ACC_W-1:0] len_lim;
    } t_limits;

    // One parser event.
    typedef struct packed {
        logic               valid;
        logic [2:0]         kind;
        logic [LEN_W-1:0]   value;
        logic [CNT_W-1:0]   arg_index;
        logic               is_null;
        logic [2:0]         error_code;
        logic               last;
        logic [BYTES_W-1:0] command_bytes;
    } t_event;

endpackage

// File: sv/resp_array_command_parser.sv
// Top level of the array command parser: input register, parser core, result register.
// Depends on rap_pkg, rap_cfg_regs, rap_parser_core and rap_out_reg.
//
// Parses a byte stream of commands framed as an array of length-prefixed strings
// ('*' count CR LF, then per argument '$' length CR LF, data, CR LF) and emits one
// event per significant byte. One byte is taken in every cycle; an event reaches the
// master side via the input register, then the result register, and a stalled master
// side holds the input back only once both registers are full. The combinational
// phase update between registers sets this rate. The user must write configuration
// only while no command bytes are in flight; the block itself does not enforce it.
module resp_array_command_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream; tdata: data_byte[7:0].
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    // Output stream; tdata: value[19:0], arg_index[31:20], is_null[32],
    // error_code[35:33], command_bytes[67:36], zero fill[71:68].
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,
    // tlast: last, the event completes the command.
    output logic        m_axis_tlast,
    // tuser: event_res[2:0].
    output logic [2:0]  m_axis_tuser,
    // Configuration writes.
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [19:0] i_cfg_data
);
    import rap_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       w_out_free;
    logic       w_advance;
    t_limits    w_limits;
    t_event     w_core_event;
    t_event     w_out_event;

    // The held byte moves on whenever the result register can take its event.
    assign w_advance     = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_out_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    rap_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_limits    (w_limits)
    );

    rap_parser_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_byte    (r_in_byte),
        .i_limits  (w_limits),
        .o_event   (w_core_event)
    );

    rap_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_advance),
        .i_event (w_core_event),
        .i_ready (m_axis_tready),
        .o_free  (w_out_free),
        .o_event (w_out_event)
    );

    // Pack the result fields onto the master side.
    assign m_axis_tvalid = w_out_event.valid;
    assign m_axis_tlast  = w_out_event.last;
    assign m_axis_tuser  = w_out_event.kind;
    assign m_axis_tdata  = {4'b0, w_out_event.command_bytes, w_out_event.error_code,
                            w_out_event.is_null, w_out_event.arg_index, w_out_event.value};

endmodule

// File: sv/rap_cfg_regs.sv
// Configuration registers of the array command parser and the effective limits.
// Depends on rap_pkg.
module rap_cfg_regs (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [19:0]           i_cfg_data,
    output rap_pkg::t_limits      o_limits
);
    import rap_pkg::*;

    logic [CNT_W-1:0] r_max_arguments;
    logic [LEN_W-1:0] r_max_bulk_length;
    logic [31:0]      w_cnt_min;
    logic [31:0]      w_len_min;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_arguments   <= CNT_W'(1024);
            r_max_bulk_length <= LEN_W'(524288);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MAX_ARGUMENTS:   r_max_arguments   <= i_cfg_data[CNT_W-1:0];
                REG_MAX_BULK_LENGTH: r_max_bulk_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // The limit used is the smaller of the register and the fixed bound.
    always_comb begin
        w_cnt_min = (32'(r_max_arguments) < 32'(COUNT_LIMIT)) ?
                    32'(r_max_arguments) : 32'(COUNT_LIMIT);
        w_len_min = (32'(r_max_bulk_length) < LENGTH_LIMIT) ?
                    32'(r_max_bulk_length) : LENGTH_LIMIT;
        o_limits.cnt_lim = w_cnt_min[ACC_W-1:0];
        o_limits.len_lim = w_len_min[ACC_W-1:0];
    end

endmodule

// File: sv/rap_parser_core.sv
// Parser state and the combinational phase update for one stream byte.
// Depends on rap_pkg and assert_macros.svh.
`include "assert_macros.svh"
module rap_parser_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_advance,
    input  logic [7:0]            i_byte,
    input  rap_pkg::t_limits      i_limits,
    output rap_pkg::t_event       o_event
);
    import rap_pkg::*;

    logic [3:0]         r_phase,           n_phase;
    logic [ACC_W-1:0]   r_acc,             n_acc;
    logic               r_negative,        n_negative;
    logic [CNT_W-1:0]   r_args_remaining,  n_args_remaining;
    logic [CNT_W-1:0]   r_current_arg,     n_current_arg;
    logic [LEN_W-1:0]   r_bytes_remaining, n_bytes_remaining;
    logic [BYTES_W-1:0] r_byte_counter,    n_byte_counter;

    logic               w_is_digit;
    logic [ACC_W+3:0]   w_acc_next;
    logic [ACC_W-1:0]   w_acc_sat;
    logic [CNT_W-1:0]   w_args_dec;
    t_event             w_ev;

    // Digit accumulation: times ten by shift and add, then saturate.
    always_comb begin
        w_is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
        w_acc_next = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                   + (ACC_W+4)'(i_byte[3:0]);
        w_acc_sat  = (w_acc_next > (ACC_W+4)'(ACC_MAX)) ? ACC_MAX : w_acc_next[ACC_W-1:0];
        w_args_dec = r_args_remaining - CNT_W'(1);
    end

    // Phase update and event generation.
    always_comb begin
        n_phase           = r_phase;
        n_acc             = r_acc;
        n_negative        = r_negative;
        n_args_remaining  = r_args_remaining;
        n_current_arg     = r_current_arg;
        n_bytes_remaining = r_bytes_remaining;
        n_byte_counter    = r_byte_counter;
        w_ev              = '0;

        // Count every byte of a command in progress, saturating.
        if (r_phase >= PH_CNT_START && r_byte_counter != {BYTES_W{1'b1}}) begin
            n_byte_counter = r_byte_counter + BYTES_W'(1);
        end

        unique case (r_phase)
            PH_IDLE, PH_DISCARD: begin
                if (i_byte == CH_STAR) begin
                    n_byte_counter    = BYTES_W'(1);
                    n_args_remaining  = '0;
                    n_current_arg     = '0;
                    n_bytes_remaining = '0;
                    n_acc             = '0;
                    n_negative        = 1'b0;
                    n_phase           = PH_CNT_START;
                end else if (r_phase == PH_IDLE) begin
                    // A stray byte between commands is reported once.
                    w_ev.valid      = 1'b1;
                    w_ev.kind       = EV_ERROR;
                    w_ev.error_code = ERR_BAD_TYPE;
                    n_phase         = PH_DISCARD;
                end
            end
            PH_CNT_START, PH_CNT_DIGITS: begin
                if (i_byte == CH_MINUS && r_phase == PH_CNT_START) begin
                    n_negative = 1'b1;
                    n_phase    = PH_CNT_DIGITS;
                end else if (w_is_digit) begin
                    n_acc   = w_acc_sat;
                    n_phase = PH_CNT_DIGITS;
                end else if (i_byte == CH_CR) begin
                    n_phase = PH_CNT_LF;
                end else begin
                    w_ev.valid      = 1'b1;
                    w_ev.kind       = EV_ERROR;
                    w_ev.error_code = ERR_BAD_COUNT;
                    n_phase         = PH_DISCARD;
                end
            end
            PH_CNT_LF: begin
                w_ev.valid = 1'b1;
                if (i_byte != CH_LF) begin
                    w_ev.kind       = EV_ERROR;
                    w_ev.error_code = ERR_BAD_TERM;
                    n_phase         = PH_DISCARD;
                end else if (r_negative && r_acc != '0) begin
                    w_ev.kind       = EV_ERROR;
                    w_ev.error_code = ERR_BAD_COUNT;
                    n_phase         = PH_DISCARD;
                end else if (r_acc > i_limits.cnt_lim) begin
                    w_ev.kind       = EV_ERROR;
                    w_ev.error_code = ERR_COUNT_BIG;
                    n_phase         = PH_DISCARD;
                end else begin
                    n_args_remaining = r_acc[CNT_W-1:0];
                    n_current_arg    = '0;
                    w_ev.kind        = EV_ARRAY_HDR;
                    if (r_acc[CNT_W-1:0] == '0) begin
                        // An empty array completes the command here.
                        w_ev.last = 1'b1;
                        n_phase   = PH_IDLE;
                    end else begin
                        w_ev.value = LEN_W'(r_acc[CNT_W-1:0]);
                        n_phase    = PH_ARG_PREFIX;
                    end
                end
            end
            PH_ARG_PREFIX: begin
                if (i_byte != CH_DOLLAR) begin
                    w_ev.valid      = 1'b1;
                    w_ev.kind       = EV_ERROR;
                    w_ev.error_code = ERR_BAD_PREFIX;
                    w_ev.arg_index  = r_current_arg;
                    n_phase         = PH_DISCARD;
                end else begin
                    n_acc      = '0;
                    n_negative = 1'b0;
                    n_phase    = PH_LEN_START;
                end
            end
            PH_LEN_START, PH_LEN_DIGITS: begin
                if (i_byte == CH_MINUS && r_phase == PH_LEN_START) begin
                    n_negative = 1'b1;
                    n_phase    = PH_LEN_DIGITS;
                end else if (w_is_digit) begin
                    n_acc   = w_acc_sat;
                    n_phase = PH_LEN_DIGITS;
                end else if (i_byte == CH_CR) begin
                    n_phase = PH_LEN_LF;
                end else begin
                    w_ev.valid      = 1'b1;
                    w_ev.kind       = EV_ERROR;
                    w_ev.error_code = ERR_BAD_LENGTH;
                    w_ev.arg_index  = r_current_arg;
                    n_phase         = PH_DISCARD;
                end
            end
            PH_LEN_LF: begin
                w_ev.valid     = 1'b1;
                w_ev.arg_index = r_current_arg;
                if (i_byte != CH_LF) begin
                    w_ev.kind       = EV_ERROR;
                    w_ev.error_code = ERR_BAD_TERM;
                    n_phase         = PH_DISCARD;
                end else if (r_negative && r_acc != '0) begin
                    if (r_acc != ACC_W'(1)) begin
                        w_ev.kind       = EV_ERROR;
                        w_ev.error_code = ERR_BAD_LENGTH;
                        n_phase         = PH_DISCARD;
                    end else begin
                        // Null string: no data and no closing line.
                        w_ev.kind        = EV_ARG_HDR;
                        w_ev.is_null     = 1'b1;
                        n_args_remaining = w_args_dec;
                        if (w_args_dec == '0) begin
                            w_ev.last = 1'b1;
                            n_phase   = PH_IDLE;
                        end else begin
                            n_current_arg = r_current_arg + CNT_W'(1);
                            n_phase       = PH_ARG_PREFIX;
                        end
                    end
                end else if (r_acc > i_limits.len_lim) begin
                    w_ev.kind       = EV_ERROR;
                    w_ev.error_code = ERR_TOO_LONG;
                    n_phase         = PH_DISCARD;
                end else begin
                    w_ev.kind         = EV_ARG_HDR;
                    w_ev.value        = r_acc[LEN_W-1:0];
                    n_bytes_remaining = r_acc[LEN_W-1:0];
                    n_phase           = (r_acc[LEN_W-1:0] == '0) ? PH_DATA_CR : PH_DATA;
                end
            end
            PH_DATA: begin
                n_bytes_remaining = r_bytes_remaining - LEN_W'(1);
                if (r_bytes_remaining == LEN_W'(1)) begin
                    n_phase = PH_DATA_CR;
                end
                w_ev.valid     = 1'b1;
                w_ev.kind      = EV_DATA;
                w_ev.value     = LEN_W'(i_byte);
                w_ev.arg_index = r_current_arg;
            end
            PH_DATA_CR: begin
                if (i_byte != CH_CR) begin
                    w_ev.valid      = 1'b1;
                    w_ev.kind       = EV_ERROR;
                    w_ev.error_code = ERR_BAD_TERM;
                    w_ev.arg_index  = r_current_arg;
                    n_phase         = PH_DISCARD;
                end else begin
                    n_phase = PH_DATA_LF;
                end
            end
            PH_DATA_LF: begin
                w_ev.valid     = 1'b1;
                w_ev.arg_index = r_current_arg;
                if (i_byte != CH_LF) begin
                    w_ev.kind       = EV_ERROR;
                    w_ev.error_code = ERR_BAD_TERM;
                    n_phase         = PH_DISCARD;
                end else begin
                    w_ev.kind        = EV_ARG_END;
                    n_args_remaining = w_args_dec;
                    if (w_args_dec == '0) begin
                        w_ev.last = 1'b1;
                        n_phase   = PH_IDLE;
                    end else begin
                        n_current_arg = r_current_arg + CNT_W'(1);
                        n_phase       = PH_ARG_PREFIX;
                    end
                end
            end
            default: begin
                n_phase = PH_DISCARD;
            end
        endcase

        // The byte count travels only with the completing event.
        w_ev.command_bytes = w_ev.last ? n_byte_counter : '0;
    end

    assign o_event = w_ev;

    // State registers advance once per transfer taken from the input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_IDLE;
            r_acc             <= '0;
            r_negative        <= 1'b0;
            r_args_remaining  <= '0;
            r_current_arg     <= '0;
            r_bytes_remaining <= '0;
            r_byte_counter    <= '0;
        end else if (i_advance) begin
            r_phase           <= n_phase;
            r_acc             <= n_acc;
            r_negative        <= n_negative;
            r_args_remaining  <= n_args_remaining;
            r_current_arg     <= n_current_arg;
            r_bytes_remaining <= n_bytes_remaining;
            r_byte_counter    <= n_byte_counter;
        end
    end

    // An error always leads into the discard phase.
    `RAP_ASSERT_NXT(a_error_discards, i_advance && w_ev.valid && w_ev.kind == EV_ERROR,
        r_phase == PH_DISCARD, "error event did not enter discard")
    // The completing event returns the parser to idle.
    `RAP_ASSERT_NXT(a_last_idles, i_advance && w_ev.valid && w_ev.last,
        r_phase == PH_IDLE, "last event did not return to idle")
    // Data bytes are only emitted while bytes of the argument remain.
    `RAP_ASSERT_IMP(a_data_in_range, w_ev.valid && w_ev.kind == EV_DATA,
        r_bytes_remaining != '0, "data event with no bytes remaining")

endmodule

// File: sv/rap_out_reg.sv
// Result register of the array command parser: holds one event until it is taken.
// Depends on rap_pkg.
module rap_out_reg (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  rap_pkg::t_event       i_event,
    input  logic                  i_ready,
    output logic                  o_free,
    output rap_pkg::t_event       o_event
);
    import rap_pkg::*;

    logic   r_valid;
    t_event r_event;

    // The register can take a new event when empty or when its event leaves now.
    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load && i_event.valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_event <= i_event;
        end
    end

    always_comb begin
        o_event       = r_event;
        o_event.valid = r_valid;
    end

endmodule

// File: tb/parser_event_checker.sv
`timescale 1ns / 100ps
// Checker of the array command parser: watches the byte, event and configuration
// channels, predicts each event from the accepted bytes and compares. Depends on rap_pkg.
module parser_event_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [71:0] i_out_data,
    input  logic        i_out_last,
    input  logic [2:0]  i_out_user,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [19:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    import rap_pkg::*;

    localparam logic [11:0] ARGS_AT_RESET = 12'd1024;
    localparam logic [19:0] LEN_AT_RESET  = 20'd524288;

    typedef struct packed {
        logic [2:0]  kind;
        logic [19:0] value;
        logic [11:0] arg_index;
        logic        is_null;
        logic [2:0]  error_code;
        logic        last;
        logic [31:0] command_bytes;
    } t_expected_event;

    t_expected_event expected_events[$];
    int              fail_total = 0;

    // Configuration copy and parser state of the prediction.
    logic [11:0] arg_limit_cfg;
    logic [19:0] max_len;
    logic [3:0]  phase;
    logic [20:0] acc;
    logic        neg_seen;
    logic [11:0] args_left;
    logic [11:0] cur_arg;
    logic [19:0] data_left;
    logic [31:0] cmd_count;

    function automatic bit make_event(output t_expected_event ev, input logic [2:0] kind,
                                      input logic [19:0] value, input logic [11:0] idx,
                                      input logic nul, input logic [2:0] err,
                                      input logic lst);
        ev.kind          = kind;
        ev.value         = value;
        ev.arg_index     = idx;
        ev.is_null       = nul;
        ev.error_code    = err;
        ev.last          = lst;
        ev.command_bytes = lst ? cmd_count : 32'd0;
        return 1'b1;
    endfunction

    // Any error sends the parser into the discard phase.
    function automatic bit flag_error(output t_expected_event ev, input logic [2:0] err,
                                      input logic [11:0] idx);
        phase = PH_DISCARD;
        return make_event(ev, EV_ERROR, 20'd0, idx, 1'b0, err, 1'b0);
    endfunction

    function automatic void add_digit(input logic [7:0] b);
        logic [31:0] sum;
        sum = {11'd0, acc} * 32'd10 + {24'd0, b - CH_ZERO};
        acc = (sum > {11'd0, ACC_MAX}) ? ACC_MAX : sum[20:0];
    endfunction

    function automatic void start_number(input logic [3:0] next_phase);
        acc      = '0;
        neg_seen = 1'b0;
        phase    = next_phase;
    endfunction

    // Closes the current argument and tells whether the command is complete.
    function automatic logic close_arg();
        args_left = args_left - 12'd1;
        if (args_left == 12'd0) begin
            phase = PH_IDLE;
            return 1'b1;
        end
        cur_arg = cur_arg + 12'd1;
        phase   = PH_ARG_PREFIX;
        return 1'b0;
    endfunction

    // Advances the predicted state by one byte; returns 1 when the byte yields an event.
    function automatic bit predict_event(input logic [7:0] b, output t_expected_event ev);
        logic [31:0] cnt_lim;
        logic [31:0] len_lim;
        logic        is_digit;
        logic        lst;
        logic [11:0] idx;
        ev       = '0;
        cnt_lim  = ({20'd0, arg_limit_cfg} < {16'd0, COUNT_LIMIT}) ? {20'd0, arg_limit_cfg}
                                                                    : {16'd0, COUNT_LIMIT};
        len_lim  = ({12'd0, max_len} < LENGTH_LIMIT) ? {12'd0, max_len} : LENGTH_LIMIT;
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        idx      = cur_arg;
        if (phase >= PH_CNT_START && cmd_count != 32'hFFFF_FFFF)
            cmd_count = cmd_count + 32'd1;
        case (phase)
            PH_IDLE, PH_DISCARD: begin
                if (b == CH_STAR) begin
                    cmd_count = 32'd1;
                    args_left = '0;
                    cur_arg   = '0;
                    data_left = '0;
                    start_number(PH_CNT_START);
                    return 1'b0;
                end
                if (phase == PH_IDLE)
                    return flag_error(ev, ERR_BAD_TYPE, 12'd0);
                return 1'b0;
            end
            PH_CNT_START, PH_CNT_DIGITS: begin
                if (b == CH_MINUS && phase == PH_CNT_START) begin
                    neg_seen = 1'b1;
                    phase    = PH_CNT_DIGITS;
                end else if (is_digit) begin
                    add_digit(b);
                    phase = PH_CNT_DIGITS;
                end else if (b == CH_CR) begin
                    phase = PH_CNT_LF;
                end else begin
                    return flag_error(ev, ERR_BAD_COUNT, 12'd0);
                end
                return 1'b0;
            end
            PH_CNT_LF: begin
                if (b != CH_LF)
                    return flag_error(ev, ERR_BAD_TERM, 12'd0);
                if (neg_seen && acc != '0)
                    return flag_error(ev, ERR_BAD_COUNT, 12'd0);
                if ({11'd0, acc} > cnt_lim)
                    return flag_error(ev, ERR_COUNT_BIG, 12'd0);
                args_left = acc[11:0];
                cur_arg   = '0;
                if (args_left == '0) begin
                    phase = PH_IDLE;
                    return make_event(ev, EV_ARRAY_HDR, 20'd0, 12'd0, 1'b0, 3'd0, 1'b1);
                end
                phase = PH_ARG_PREFIX;
                return make_event(ev, EV_ARRAY_HDR, {8'd0, args_left}, 12'd0, 1'b0, 3'd0,
                                  1'b0);
            end
            PH_ARG_PREFIX: begin
                if (b != CH_DOLLAR)
                    return flag_error(ev, ERR_BAD_PREFIX, idx);
                start_number(PH_LEN_START);
                return 1'b0;
            end
            PH_LEN_START, PH_LEN_DIGITS: begin
                if (b == CH_MINUS && phase == PH_LEN_START) begin
                    neg_seen = 1'b1;
                    phase    = PH_LEN_DIGITS;
                end else if (is_digit) begin
                    add_digit(b);
                    phase = PH_LEN_DIGITS;
                end else if (b == CH_CR) begin
                    phase = PH_LEN_LF;
                end else begin
                    return flag_error(ev, ERR_BAD_LENGTH, idx);
                end
                return 1'b0;
            end
            PH_LEN_LF: begin
                if (b != CH_LF)
                    return flag_error(ev, ERR_BAD_TERM, idx);
                if (neg_seen && acc != '0) begin
                    // Length -1 is a null string: no data and no closing CR LF.
                    if (acc != 21'd1)
                        return flag_error(ev, ERR_BAD_LENGTH, idx);
                    lst = close_arg();
                    return make_event(ev, EV_ARG_HDR, 20'd0, idx, 1'b1, 3'd0, lst);
                end
                if ({11'd0, acc} > len_lim)
                    return flag_error(ev, ERR_TOO_LONG, idx);
                data_left = acc[19:0];
                phase     = (data_left == '0) ? PH_DATA_CR : PH_DATA;
                return make_event(ev, EV_ARG_HDR, data_left, idx, 1'b0, 3'd0, 1'b0);
            end
            PH_DATA: begin
                data_left = data_left - 20'd1;
                if (data_left == '0)
                    phase = PH_DATA_CR;
                return make_event(ev, EV_DATA, {12'd0, b}, idx, 1'b0, 3'd0, 1'b0);
            end
            PH_DATA_CR: begin
                if (b != CH_CR)
                    return flag_error(ev, ERR_BAD_TERM, idx);
                phase = PH_DATA_LF;
                return 1'b0;
            end
            PH_DATA_LF: begin
                if (b != CH_LF)
                    return flag_error(ev, ERR_BAD_TERM, idx);
                lst = close_arg();
                return make_event(ev, EV_ARG_END, 20'd0, idx, 1'b0, 3'd0, lst);
            end
            default: begin
                phase = PH_DISCARD;
                return 1'b0;
            end
        endcase
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_total++;
        end
    endtask

    // Compare event transfers, track configuration writes and predict byte transfers.
    always @(posedge i_clk) begin
        t_expected_event want;
        t_expected_event fresh;
        if (!i_rst_n) begin
            arg_limit_cfg = ARGS_AT_RESET;
            max_len       = LEN_AT_RESET;
            phase         = PH_IDLE;
            acc           = '0;
            neg_seen      = 1'b0;
            args_left     = '0;
            cur_arg       = '0;
            data_left     = '0;
            cmd_count     = '0;
            expected_events.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: event with no expectation, expected none, actual kind %0d",
                             $time, i_out_user);
                    fail_total++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("kind", 32'(want.kind), 32'(i_out_user));
                    check_field("value", 32'(want.value), 32'(i_out_data[19:0]));
                    check_field("arg_index", 32'(want.arg_index), 32'(i_out_data[31:20]));
                    check_field("is_null", 32'(want.is_null), 32'(i_out_data[32]));
                    check_field("error_code", 32'(want.error_code),
                                32'(i_out_data[35:33]));
                    check_field("last", 32'(want.last), 32'(i_out_last));
                    check_field("command_bytes", want.command_bytes, i_out_data[67:36]);
                    check_field("zero fill", 32'd0, 32'(i_out_data[71:68]));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_index == REG_MAX_ARGUMENTS)
                    arg_limit_cfg = i_cfg_data[11:0];
                else
                    max_len = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) begin
                if (predict_event(i_in_data, fresh))
                    expected_events.push_back(fresh);
            end
        end
        o_pending    <= expected_events.size();
        o_fail_count <= fail_total;
    end

endmodule

// File: tb/tb_resp_array_command_parser.sv
`timescale 1ns / 100ps
// Top of the array command parser testbench: clock, reset, byte stimulus,
// configuration phases and the verdict. Depends on rap_pkg and parser_event_checker.
module tb_resp_array_command_parser;
    import rap_pkg::*;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'd0;
    logic        m_tready  = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [19:0] cfg_data  = 20'd0;

    logic        s_axis_tready;
    logic        m_axis_tvalid;
    logic [71:0] m_axis_tdata;
    logic        m_axis_tlast;
    logic [2:0]  m_axis_tuser;
    int          fail_count;
    int          pending;

    logic [7:0]  stream_q[$];
    int          cur_max_args = 1024;
    int          cur_max_len  = 524288;
    int          ready_mode   = 0;
    int          ready_left   = 0;

    resp_array_command_parser u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    parser_event_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_last   (m_axis_tlast),
        .i_out_user   (m_axis_tuser),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #10 i_clk = ~i_clk;

    // The receiver switches between always ready, coin-flip ready and mostly stalled.
    always @(posedge i_clk) begin
        if (ready_left == 0) begin
            ready_mode <= $urandom_range(0, 3);
            ready_left <= $urandom_range(8, 64);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            0, 1:    m_tready <= 1'b1;
            2:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic put_byte(input logic [7:0] b);
        stream_q.push_back(b);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            stream_q.push_back(s[i]);
    endtask

    task automatic put_crlf();
        stream_q.push_back(CH_CR);
        stream_q.push_back(CH_LF);
    endtask

    // Decimal digits, now and then with a leading zero.
    task automatic put_num(input int unsigned v);
        if ($urandom_range(0, 7) == 0)
            stream_q.push_back(CH_ZERO);
        put_text($sformatf("%0d", v));
    endtask

    // One command, mostly well formed, sometimes with a byte replaced,
    // a byte inserted or the tail cut off.
    task automatic add_command();
        int n;
        int len;
        int r;
        int start;
        int pos;
        start = stream_q.size();
        put_byte(CH_STAR);
        r = $urandom_range(0, 31);
        if (r == 0) begin
            put_text("9999999");
            n = 0;
        end else if (r == 1) begin
            put_byte(CH_MINUS);
            n = $urandom_range(0, 3);
            put_num(n);
            n = 0;
        end else if (r == 2 && cur_max_args <= 8) begin
            n = cur_max_args + $urandom_range(0, 1);
            put_num(n);
        end else begin
            n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
            put_num(n);
        end
        put_crlf();
        for (int i = 0; i < n; i++) begin
            put_byte(CH_DOLLAR);
            r = $urandom_range(0, 15);
            if (r == 0) begin
                put_text("-1");
                len = -1;
            end else if (r == 1) begin
                len = 0;
            end else if (r == 2) begin
                put_byte(CH_MINUS);
                put_num($urandom_range(2, 9));
                len = -1;
            end else if (r == 3) begin
                put_text("12345678");
                len = -1;
            end else if (r == 4 && cur_max_len <= 16) begin
                len = cur_max_len + $urandom_range(0, 1);
            end else begin
                len = $urandom_range(1, 10);
            end
            if (len >= 0)
                put_num(len);
            put_crlf();
            if (len >= 0) begin
                for (int k = 0; k < len; k++)
                    put_byte(8'($urandom_range(0, 255)));
                put_crlf();
            end
        end
        if ($urandom_range(0, 4) == 0) begin
            pos = $urandom_range(start, stream_q.size() - 1);
            case ($urandom_range(0, 2))
                0: stream_q[pos] = 8'($urandom_range(0, 255));
                1: stream_q.insert(pos, 8'($urandom_range(0, 255)));
                default: begin
                    while (stream_q.size() > pos)
                        void'(stream_q.pop_back());
                end
            endcase
        end
        // Occasional stray bytes between commands.
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 4))
                put_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Sends the queued bytes in bursts of random length with random gaps.
    task automatic send_stream();
        int         burst_left;
        int         gap;
        logic [7:0] b;
        burst_left = 0;
        while (stream_q.size() > 0) begin
            b = stream_q.pop_front();
            if (burst_left == 0) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0) begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                          : $urandom_range(1, 24);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= b;
            do @(posedge i_clk); while (!s_axis_tready);
            burst_left--;
        end
        s_tvalid <= 1'b0;
    endtask

    // Waits for every expected event, then for the pipeline to drain.
    task automatic settle();
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic index, input logic [19:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_limits(input int args, input int len);
        cur_max_args = args;
        cur_max_len  = len;
        cfg_write(REG_MAX_ARGUMENTS, 20'(args));
        cfg_write(REG_MAX_BULK_LENGTH, 20'(len));
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed commands under the reset limits.
        put_byte(8'hFF);
        put_byte(8'h00);
        put_text("*0"); put_crlf();
        put_text("*-"); put_crlf();
        put_text("*"); put_crlf();
        put_text("*3"); put_crlf();
        put_text("$-1"); put_crlf();
        put_text("$2"); put_crlf(); put_byte(8'hFF); put_byte(8'h00); put_crlf();
        put_text("$0"); put_crlf(); put_crlf();
        put_text("*-2"); put_crlf();
        put_text("*1-");
        put_text("*9999999"); put_crlf();
        put_text("*1"); put_crlf(); put_text("x");
        put_text("*1"); put_crlf(); put_text("$-2"); put_crlf();
        put_text("*1"); put_crlf(); put_text("$1-");
        put_text("*1"); put_crlf(); put_text("$99999999"); put_crlf();
        put_text("*1"); put_byte(CH_CR); put_text("x");
        put_text("*1"); put_crlf(); put_text("$1"); put_byte(CH_CR); put_byte(8'h00);
        put_text("*1"); put_crlf(); put_text("$1"); put_crlf(); put_text("ab");
        put_text("*1"); put_crlf(); put_text("$0"); put_crlf(); put_byte(CH_CR);
        put_text("x");
        send_stream();
        settle();

        // Random phases, each under its own limits, the extremes among them.
        for (int p = 0; p < 6; p++) begin
            case (p)
                0: set_limits(4095, 1048575);
                1: set_limits(0, 0);
                2: set_limits(1, 3);
                3: set_limits($urandom_range(0, 8), $urandom_range(0, 16));
                4: set_limits($urandom_range(0, 4095), $urandom_range(0, 1048575));
                default: set_limits(2, 10);
            endcase
            while (stream_q.size() < 105)
                add_command();
            send_stream();
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("resp_array_command_parser regression: pass");
        end else begin
            $display("resp_array_command_parser regression: fail");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(10_000_000);
        $display("resp_array_command_parser regression: fail");
        $finish;
    end

endmodule
